// File: design/osp_pkg.sv
// osp_pkg: constants, index root table and helper functions for the option symbol parser.
// No dependencies.
package osp_pkg;

    localparam int ROOT_MAX_DEF    = 6;
    localparam int INDEX_ROOTS_DEF = 14;
    localparam int TABLE_LEN       = 14;
    localparam int TAIL_LEN        = 15;
    localparam int MIN_LEN         = 16;
    localparam int COUNT_MAX       = 31;
    localparam int PACK_BYTES      = 6;
    localparam int CW              = 5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CALL  = 8'h43;
    localparam logic [7:0] CH_PUT   = 8'h50;

    // place weights of the eight strike digits, most significant first
    localparam logic [26:0] STRIKE_WT [8] = '{
        27'd10000000, 27'd1000000, 27'd100000, 27'd10000,
        27'd1000,     27'd100,     27'd10,     27'd1
    };

    typedef struct packed {
        logic [47:0] root;
        logic [47:0] under;
        logic        am;
        logic        american;
    } t_idx_entry;

    localparam t_idx_entry IDX_TABLE [TABLE_LEN] = '{
        '{48'h535058000000, 48'h535058000000, 1'b1, 1'b0},
        '{48'h535058570000, 48'h535058000000, 1'b0, 1'b0},
        '{48'h585350000000, 48'h585350000000, 1'b0, 1'b0},
        '{48'h4E4458000000, 48'h4E4458000000, 1'b1, 1'b0},
        '{48'h4E4458500000, 48'h4E4458000000, 1'b0, 1'b0},
        '{48'h584E44000000, 48'h584E44000000, 1'b0, 1'b0},
        '{48'h525554000000, 48'h525554000000, 1'b1, 1'b0},
        '{48'h525554570000, 48'h525554000000, 1'b0, 1'b0},
        '{48'h4D5255540000, 48'h4D5255540000, 1'b0, 1'b0},
        '{48'h564958000000, 48'h564958000000, 1'b1, 1'b0},
        '{48'h564958570000, 48'h564958000000, 1'b1, 1'b0},
        '{48'h444A58000000, 48'h444A58000000, 1'b1, 1'b0},
        '{48'h4F4558000000, 48'h4F4558000000, 1'b0, 1'b1},
        '{48'h58454F000000, 48'h4F4558000000, 1'b0, 1'b0}
    };

    // datapath commands and status
    typedef struct packed {
        logic shift;   // take one character
        logic clear;   // back to reset contents
        logic check;   // register the check stage
    } t_dp_cmd;

    typedef struct packed {
        logic busy;    // check result pending
    } t_dp_sts;

    // request payload of the character channel
    typedef struct packed {
        logic [7:0] symbol_char;
        logic       last_char;
    } t_sym_req;

    typedef struct packed {
        logic        parse_ok;
        logic [47:0] root_text;
        logic [47:0] underlying_text;
        logic [6:0]  expiry_year;
        logic [3:0]  expiry_month;
        logic [4:0]  expiry_day;
        logic        is_call;
        logic [26:0] strike_milli;
        logic        american_style;
        logic        am_settled;
        logic        standard_contract;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

// File: design/osp_if.sv
// osp_if: valid/ready channel carrying one payload.
// Depends on nothing; payload type is a parameter.
interface osp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/option_symbol_parser.sv
// option_symbol_parser: top level, controller plus datapath.
// Depends on osp_pkg, osp_if, osp_ctrl, osp_dp.
//
//  channel   dir  payload                              request when
//  in_ch     in   symbol_char, last_char               valid & ready
//  out_ch    out  parse result (11 fields)             valid & ready
//
// One character per cycle while a symbol streams in.
// The edge that takes the last character enters the check state with input held off;
// the result register loads at the next edge and out_ch.valid rises with it.
// While a result waits, the next symbol's characters keep flowing; only its last
// character is held until the waiting result is taken.
// Synchronous active-low reset clears all character state.
module option_symbol_parser import osp_pkg::*; #(
    parameter int ROOT_MAX    = ROOT_MAX_DEF,
    parameter int INDEX_ROOTS = INDEX_ROOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    osp_if.sink   in_ch,
    osp_if.source out_ch
);
    t_dp_cmd cmd;
    t_result res;

    osp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_last(in_ch.data.last_char),
        .o_in_ready(in_ch.ready), .i_out_ready(out_ch.ready),
        .o_out_valid(out_ch.valid), .o_cmd(cmd)
    );

    osp_dp #(.ROOT_MAX(ROOT_MAX), .INDEX_ROOTS(INDEX_ROOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_char(in_ch.data.symbol_char), .o_res(res)
    );

    assign out_ch.data = res;
endmodule

// File: design/osp_ctrl.sv
// osp_ctrl: controller; accepts characters, runs the check step, holds the result request.
// Depends on osp_pkg.
module osp_ctrl import osp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);
    typedef enum logic [1:0] {S_RUN, S_CHECK, S_HOLD} t_state;
    t_state r_state, n_state;
    logic   acc;

    // while a result waits, only a last character that would overwrite it is held
    assign o_in_ready  = (r_state == S_RUN) ||
                         ((r_state == S_HOLD) && (i_out_ready || !i_in_last));
    assign o_out_valid = (r_state == S_HOLD);
    assign acc         = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.shift = acc;
        o_cmd.check = (r_state == S_CHECK);
        o_cmd.clear = (r_state == S_CHECK);
        n_state = r_state;
        case (r_state)
            S_RUN:   if (acc && i_in_last) n_state = S_CHECK;
            S_CHECK: n_state = S_HOLD;
            S_HOLD: begin
                if (acc && i_in_last) n_state = S_CHECK;
                else if (i_out_ready) n_state = S_RUN;
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_RUN;
        else          r_state <= n_state;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && i_in_valid && o_in_ready) |-> !i_in_last)
        else $error("last character taken while result waits");
    a_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.check |=> o_out_valid) else $error("check not followed by result");
endmodule

// File: design/osp_dp.sv
// osp_dp: datapath; head and tail shift registers, count, spill flag, check and result register.
// Depends on osp_pkg.
module osp_dp import osp_pkg::*; #(
    parameter int ROOT_MAX    = ROOT_MAX_DEF,
    parameter int INDEX_ROOTS = INDEX_ROOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_char,
    output t_result    o_res
);
    localparam int NB = (ROOT_MAX < PACK_BYTES) ? ROOT_MAX : PACK_BYTES;

    logic [7:0]    r_head [ROOT_MAX];
    logic [7:0]    r_tail [TAIL_LEN];
    logic [CW-1:0] r_count;
    logic          r_spill;
    t_result       r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < ROOT_MAX; i++) r_head[i] <= '0;
            for (int i = 0; i < TAIL_LEN; i++) r_tail[i] <= '0;
            r_count <= '0;
            r_spill <= 1'b0;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < ROOT_MAX; i++)
                if (r_count == CW'(i)) r_head[i] <= i_char;
            if (r_count >= CW'(TAIL_LEN) &&
                (r_count >= CW'(COUNT_MAX) || r_count - CW'(TAIL_LEN) >= CW'(ROOT_MAX)) &&
                r_tail[0] != CH_SPACE)
                r_spill <= 1'b1;
            for (int i = 0; i < TAIL_LEN - 1; i++) r_tail[i] <= r_tail[i + 1];
            r_tail[TAIL_LEN-1] <= i_char;
            if (r_count != CW'(COUNT_MAX)) r_count <= r_count + 1'b1;
        end
    end

    // combinational check of the stored symbol
    t_result    n_res;
    logic [CW-1:0] n_len, m_len, k_len;
    logic       ok, hit, digs, blank;
    logic [6:0] yy, mm, dd;
    logic [4:0] mdays;
    logic [47:0] rt, ut;
    logic [26:0] sp [8];

    always_comb begin
        n_res = '0;
        n_len = r_count - CW'(TAIL_LEN);
        if (n_len > CW'(ROOT_MAX)) n_len = CW'(ROOT_MAX);
        m_len = '0;
        blank = 1'b1;
        for (int i = ROOT_MAX - 1; i >= 0; i--)
            if (CW'(i) < n_len && blank && r_head[i] != CH_SPACE) begin
                m_len = CW'(i + 1);
                blank = 1'b0;
            end
        ok = (r_count >= CW'(MIN_LEN)) && !r_spill && (m_len != '0);
        for (int i = 0; i < ROOT_MAX; i++)
            if (CW'(i) < m_len && !is_alnum(r_head[i])) ok = 1'b0;
        digs = 1'b1;
        for (int i = 0; i < TAIL_LEN; i++)
            if (i != 6 && !is_digit(r_tail[i])) digs = 1'b0;
        yy = 7'(r_tail[0][3:0]) * 7'd10 + 7'(r_tail[1][3:0]);
        mm = 7'(r_tail[2][3:0]) * 7'd10 + 7'(r_tail[3][3:0]);
        dd = 7'(r_tail[4][3:0]) * 7'd10 + 7'(r_tail[5][3:0]);
        case (mm)
            7'd2:                      mdays = (yy[1:0] == 2'b00) ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   mdays = 5'd30;
            default:                   mdays = 5'd31;
        endcase
        if (!digs || mm < 7'd1 || mm > 7'd12 || dd < 7'd1 || dd > {2'b00, mdays})
            ok = 1'b0;
        if (r_tail[6] != CH_CALL && r_tail[6] != CH_PUT) ok = 1'b0;
        rt = '0;
        for (int i = 0; i < NB; i++)
            if (CW'(i) < m_len) rt[8*(PACK_BYTES-1-i) +: 8] = r_head[i];
        hit = 1'b0;
        n_res.american_style = 1'b1;
        ut = '0;
        for (int i = 0; i < TABLE_LEN; i++)
            if (i < INDEX_ROOTS && !hit && m_len <= CW'(PACK_BYTES) &&
                IDX_TABLE[i].root == rt) begin
                hit = 1'b1;
                ut = IDX_TABLE[i].under;
                n_res.am_settled = IDX_TABLE[i].am;
                n_res.american_style = IDX_TABLE[i].american;
            end
        k_len = m_len;
        if (!hit) begin
            for (int i = ROOT_MAX - 1; i >= 1; i--)
                if (k_len == CW'(i + 1) && is_digit(r_head[i])) k_len = CW'(i);
            for (int i = 0; i < NB; i++)
                if (CW'(i) < k_len) ut[8*(PACK_BYTES-1-i) +: 8] = r_head[i];
        end
        n_res.parse_ok = 1'b1;
        n_res.root_text = rt;
        n_res.underlying_text = ut;
        n_res.expiry_year = yy;
        n_res.expiry_month = mm[3:0];
        n_res.expiry_day = dd[4:0];
        n_res.is_call = (r_tail[6] == CH_CALL);
        // strike digits weighted in parallel, summed as a balanced tree
        for (int i = 0; i < 8; i++)
            sp[i] = 27'(r_tail[7 + i][3:0]) * STRIKE_WT[i];
        n_res.strike_milli = ((sp[0] + sp[1]) + (sp[2] + sp[3])) +
                             ((sp[4] + sp[5]) + (sp[6] + sp[7]));
        n_res.standard_contract = (k_len == m_len);
        if (!ok) n_res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) r_res <= n_res;
    end
    assign o_res = r_res;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_count == '0) else $error("count not cleared");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(COUNT_MAX) && i_cmd.shift && !i_cmd.clear) |=> r_count == CW'(COUNT_MAX))
        else $error("count wrapped");
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.check) && r_res.parse_ok |-> r_res.expiry_month != '0)
        else $error("bad month accepted");
endmodule

// File: tb/tb_option_symbol_parser.sv
// tb_option_symbol_parser: self-checking testbench for option_symbol_parser.
// Streams directed and random option symbols, predicts each parse result and
// compares the whole result at once. Depends on osp_pkg, osp_if and the RTL top.
module tb_option_symbol_parser;
    import osp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        int    idx_root;    // >= 0: prefix the text with that index root
        string text;
        bit    rejects;     // expected result typed in: all zero
    } t_row;

    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 37;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    osp_if #(.T(t_sym_req)) in_ch ();
    osp_if #(.T(t_result))  out_ch ();

    option_symbol_parser dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state, mirrors the parser's character store
    logic [7:0] head_q [6];
    logic [7:0] tail_q [15];
    int         nchars;
    bit         spill;
    bit         typed_reject;   // current symbol carries a typed expectation

    t_result parse_queue [$];
    int      errors = 0;
    int      cycles = 0;
    int      chars_sent = 0;
    bit      calm = 1'b0;       // no idling on either side while set

    function automatic int month_len(int yy, int mm);
        case (mm)
            2:          return (yy % 4 == 0) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alnum_ch(logic [7:0] c);
        return digit_ch(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [47:0] pack6(logic [7:0] s [6], int n);
        logic [47:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v[47 - 8*i -: 8] = s[i];
        return v;
    endfunction

    // parse the symbol held in the predictor state
    function automatic t_result evaluate_symbol();
        t_result     r;
        int          n, m, k, yy, mm, dd;
        int          strike;
        logic [7:0]  root [6];
        bit          hit;
        r = '0;
        if (nchars < MIN_LEN || spill) return r;
        n = nchars - TAIL_LEN;
        if (n > 6) n = 6;
        m = n;
        while (m > 0 && head_q[m-1] == CH_SPACE) m--;
        if (m == 0) return r;
        for (int i = 0; i < 6; i++) root[i] = 8'h00;
        for (int i = 0; i < m; i++) begin
            if (!alnum_ch(head_q[i])) return r;
            root[i] = head_q[i];
        end
        for (int i = 0; i < TAIL_LEN; i++)
            if (i != 6 && !digit_ch(tail_q[i])) return r;
        yy = (tail_q[0] - "0") * 10 + (tail_q[1] - "0");
        mm = (tail_q[2] - "0") * 10 + (tail_q[3] - "0");
        dd = (tail_q[4] - "0") * 10 + (tail_q[5] - "0");
        if (mm < 1 || mm > 12 || dd < 1 || dd > month_len(yy, mm)) return r;
        if (tail_q[6] != CH_CALL && tail_q[6] != CH_PUT) return r;
        strike = 0;
        for (int i = 7; i < TAIL_LEN; i++) strike = strike * 10 + (tail_q[i] - "0");

        r.parse_ok           = 1'b1;
        r.root_text          = pack6(root, m);
        r.expiry_year        = 7'(yy);
        r.expiry_month       = 4'(mm);
        r.expiry_day         = 5'(dd);
        r.is_call            = tail_q[6] == CH_CALL;
        r.strike_milli       = 27'(strike);
        r.american_style     = 1'b1;
        r.am_settled         = 1'b0;
        r.standard_contract  = 1'b1;
        hit = 1'b0;
        for (int i = 0; i < INDEX_ROOTS_DEF; i++) begin
            if (!hit && IDX_TABLE[i].root == r.root_text) begin
                hit                = 1'b1;
                r.underlying_text  = IDX_TABLE[i].under;
                r.am_settled       = IDX_TABLE[i].am;
                r.american_style   = IDX_TABLE[i].american;
            end
        end
        if (!hit) begin
            // equity root: strip trailing digits, keep at least one char
            k = m;
            while (k > 1 && digit_ch(root[k-1])) k--;
            r.standard_contract = (k == m);
            r.underlying_text   = pack6(root, k);
        end
        return r;
    endfunction

    function automatic void clear_symbol();
        foreach (head_q[i]) head_q[i] = 8'h00;
        foreach (tail_q[i]) tail_q[i] = 8'h00;
        nchars = 0;
        spill  = 1'b0;
    endfunction

    // advance the predictor by one accepted character
    function automatic void take_char(logic [7:0] c, logic last);
        if (nchars < 6) head_q[nchars] = c;
        if (nchars >= TAIL_LEN &&
            (nchars >= COUNT_MAX || nchars - TAIL_LEN >= 6) && tail_q[0] != CH_SPACE)
            spill = 1'b1;
        for (int i = 0; i < TAIL_LEN - 1; i++) tail_q[i] = tail_q[i+1];
        tail_q[TAIL_LEN-1] = c;
        if (nchars < COUNT_MAX) nchars++;
        if (last) begin
            parse_queue.push_back(typed_reject ? t_result'('0) : evaluate_symbol());
            clear_symbol();
        end
    endfunction

    // one character request; prediction runs on acceptance
    task automatic send_char(logic [7:0] c, logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{symbol_char: c, last_char: last};
        do @(posedge i_clk); while (!in_ch.ready);
        take_char(c, last);
        chars_sent++;
    endtask

    task automatic send_symbol(logic [7:0] s [$]);
        foreach (s[i]) send_char(s[i], i == s.size() - 1);
    endtask

    function automatic logic [7:0] rand_alnum();
        int v;
        v = $urandom_range(61);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        return 8'("0" + v - 52);
    endfunction

    function automatic void add_index_root(ref logic [7:0] s [$], input int i);
        for (int b = 0; b < 6; b++)
            if (IDX_TABLE[i].root[47 - 8*b -: 8] != 8'h00)
                s.push_back(IDX_TABLE[i].root[47 - 8*b -: 8]);
    endfunction

    function automatic void add_digits(ref logic [7:0] s [$], input int v, int w);
        for (int i = w - 1; i >= 0; i--) s.push_back(8'("0" + (v / (10 ** i)) % 10));
    endfunction

    // mostly well-formed symbols with random content, the rest broken
    function automatic void make_symbol(ref logic [7:0] s [$]);
        int kind, len, yy, mm, dd, pos;
        s.delete();
        kind = $urandom_range(99);
        if (kind >= 92) begin
            len = $urandom_range(1, 40);
            repeat (len) s.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(5) == 0) begin
            add_index_root(s, $urandom_range(TABLE_LEN - 1));
        end else begin
            len = $urandom_range(1, 6);
            repeat (len) s.push_back(rand_alnum());
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 3))
                    if (s.size() < 6) s.push_back(8'("0" + $urandom_range(9)));
        end
        repeat ($urandom_range(0, 6 - s.size())) s.push_back(CH_SPACE);
        yy = $urandom_range(99);
        mm = $urandom_range(1, 12);
        dd = $urandom_range(1, month_len(yy, mm));
        add_digits(s, yy, 2);
        add_digits(s, mm, 2);
        add_digits(s, dd, 2);
        s.push_back($urandom_range(1) ? CH_CALL : CH_PUT);
        case ($urandom_range(3))
            0:       add_digits(s, 0, 8);
            1:       add_digits(s, 99999999, 8);
            default: add_digits(s, $urandom_range(99999999), 8);
        endcase
        if (kind >= 70) begin
            pos = $urandom_range(s.size() - 1);
            case (kind % 5)
                0: s[pos] = 8'($urandom_range(255));
                1: s.delete(pos);
                2: repeat ($urandom_range(1, 25)) s.insert(0, rand_alnum());
                3: repeat ($urandom_range(1, 20)) s.insert(0, CH_SPACE);
                default: begin  // day or month out of range
                    s[s.size() - 13 + ($urandom_range(1) ? 0 : 2)] = "9";
                    s[s.size() - 12] = "9";
                end
            endcase
        end
    endfunction

    t_row rows [] = '{
        '{-1, "A240229C00000001", 1'b0},              // leap day
        '{-1, "A230229C00000001", 1'b1},              // Feb 29 in common year
        '{-1, "ZZZZZZ991231P99999999", 1'b0},         // full root, top strike
        '{-1, "a00001C00000000", 1'b1},               // short symbol
        '{-1, "abc12 000101C00000000", 1'b0},         // trailing digits stripped
        '{-1, "123456240101P00000500", 1'b0},         // all-digit root
        '{-1, "AB CD 240101C00000001", 1'b1},         // space inside root
        '{-1, "      240101C00000001", 1'b1},         // all-space root
        '{-1, "ABCDEFG240101C00000001", 1'b1},        // root too long
        '{-1, "A241301C00000001", 1'b1},              // month 13
        '{-1, "A240100C00000001", 1'b1},              // day 0
        '{-1, "A240101X00000001", 1'b1},              // neither call nor put
        '{-1, "A$0101240101C00000001", 1'b1},         // non-alphanumeric root
        '{-1, "Q                    240101C12345678", 1'b0}, // count saturates
        '{-1, "QQQQQQQQQQQQQQQQQQQQQQQQ240101C12345678", 1'b1},
        '{0, "240315C00450000", 1'b0}, '{1, "240315P00450000", 1'b0},
        '{2, "991231C00000001", 1'b0}, '{3, "240315C00450000", 1'b0},
        '{4, "240315P00450000", 1'b0}, '{5, "240315C00450000", 1'b0},
        '{6, "240315P00450000", 1'b0}, '{7, "240315C00450000", 1'b0},
        '{8, "240315P00450000", 1'b0}, '{9, "240315C00450000", 1'b0},
        '{10, "240315P00450000", 1'b0}, '{11, "240315C00450000", 1'b0},
        '{12, "240315P00450000", 1'b0}, '{13, "240315C00450000", 1'b0}
    };

    // result side: random stall, compare against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (parse_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", out_ch.data);
            end else begin
                want = parse_queue.pop_front();
                if (out_ch.data !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, out_ch.data);
                end
            end
        end
        out_ch.ready <= i_rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] sym [$];
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        typed_reject = 1'b0;
        clear_symbol();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (rows[r]) begin
            sym.delete();
            if (rows[r].idx_root >= 0) add_index_root(sym, rows[r].idx_root);
            for (int i = 0; i < rows[r].text.len(); i++) sym.push_back(rows[r].text[i]);
            typed_reject = rows[r].rejects;
            send_symbol(sym);
        end
        typed_reject = 1'b0;

        // random symbols, with a stretch of back-to-back traffic
        while (chars_sent < 1250) begin
            calm = chars_sent > 600 && chars_sent < 850;
            make_symbol(sym);
            send_symbol(sym);
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        while (parse_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: filelist.f
design/osp_pkg.sv
design/osp_if.sv
design/osp_ctrl.sv
design/osp_dp.sv
design/option_symbol_parser.sv
tb/tb_option_symbol_parser.sv
